// ----- rtl/text_graphics_pixel_generator_top_defines.svh -----
// Assertion macros for the pixel generator RTL.
// Needs clk in the scope of each use, and arst_n for TGPG_ASSERT.
`ifndef TEXT_GRAPHICS_PIXEL_GENERATOR_TOP_DEFINES_SVH
`define TEXT_GRAPHICS_PIXEL_GENERATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset only
`define TGPG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checked at every edge, reset included
`define TGPG_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TGPG_ASSERT(lbl, prop, msg)
`define TGPG_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ----- rtl/tgpg_pkg.sv -----
// Package for the text and graphics pixel generator: codes, types, level decode.
// No dependencies.
package tgpg_pkg;

	// input item kinds
	localparam logic OP_UNIT = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// pixel formats
	localparam logic [2:0] FMT_TEXT      = 3'd0;
	localparam logic [2:0] FMT_WORD_2BPP = 3'd1;
	localparam logic [2:0] FMT_WORD_1BPP = 3'd2;
	localparam logic [2:0] FMT_BYTE_1BPP = 3'd3;
	localparam logic [2:0] FMT_BYTE_2BPP = 3'd4;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_PIXEL_FORMAT  = 2'd0;
	localparam logic [1:0] REG_BLINK_EN      = 2'd1;
	localparam logic [1:0] REG_TOGGLE_PERIOD = 2'd2;

	localparam logic [15:0] TOGGLE_PERIOD_RESET = 16'd16;

	// grey levels
	localparam logic [7:0] GREY_BLACK  = 8'h00;
	localparam logic [7:0] GREY_DIM    = 8'h80;
	localparam logic [7:0] GREY_NORMAL = 8'hc0;
	localparam logic [7:0] GREY_WHITE  = 8'hff;

	// configuration seen by the front end
	typedef struct packed {
		logic [2:0]  pixel_format;
		logic        text_blink_enable;
		logic [15:0] toggle_period;
		logic        rate_wr;
		logic [15:0] rate_wdata;
	} cfg_t;

	// one classified unit waiting for expansion
	typedef struct packed {
		logic [15:0] bits;      // leftmost pixel in the top bits
		logic        two_bpp;
		logic [3:0]  last_idx;  // pixel count minus one
		logic [7:0]  fg;
		logic [7:0]  bg;
	} unit_t;

	typedef struct packed {
		logic [7:0] fg;
		logic [7:0] bg;
	} levels_t;

	function automatic logic [7:0] level_of(logic [3:0] nib, logic bright_bg);
		if (nib == 4'd0)
			return GREY_BLACK;
		if (!nib[3])
			return GREY_NORMAL;
		if (nib == 4'd8)
			return GREY_DIM;
		return bright_bg ? GREY_DIM : GREY_WHITE;
	endfunction

	// attribute to foreground and background grey
	function automatic levels_t attr_levels(logic [7:0] a);
		levels_t r;
		logic [3:0] f;
		logic [3:0] b;
		f = a[3:0];
		b = a[7:4];
		if (b == 4'd0) begin
			r.bg = GREY_BLACK;
			r.fg = level_of(f, 1'b0);
		end else if (!b[3]) begin
			r.bg = GREY_NORMAL;
			r.fg = f[3] ? level_of(f, 1'b0) : GREY_BLACK;
		end else if (b == 4'd8) begin
			r.bg = GREY_DIM;
			r.fg = level_of(f, 1'b0);
		end else begin
			r.bg = GREY_WHITE;
			r.fg = level_of(f, 1'b1);
		end
		if (f == b)
			r.fg = r.bg;
		return r;
	endfunction

endpackage

// ----- rtl/text_graphics_pixel_generator_top.sv -----
// Top level of the text and graphics pixel generator: register port and wiring.
// Depends on tgpg_pkg, tgpg_front, tgpg_fifo and tgpg_back.
//
// Channel | Dir | Handshake               | Payload
// s_      | in  | s_tvalid / s_tready     | tdata: word, glyph, attr, cursor; tuser: opcode
// m_      | out | m_tvalid / m_tready     | tdata: grey; tlast: last pixel of unit
// APB     | in  | psel & penable & pwrite | format, blink enable, toggle period
//
// One pixel leaves per clock from the back-end shifter unless m_tready holds the output:
// a text or 1bpp word unit gives 16 pixels, 8 for word 2bpp or byte 1bpp, 4 for byte 2bpp.
// A frame tick is taken on the input and gives no pixel.
// An accepted unit passes the unit queue and the back-end shifter before its
// first pixel is valid in the output register.
// The input stalls only while the unit queue is full; no clearing pass after reset.
module text_graphics_pixel_generator_top import tgpg_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // [15:0] data_word, [31:16] glyph_row,
	                              // [39:32] attribute, [55:40] cursor_mask
	input  logic        s_tuser,  // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] grey
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [2:0]  pixel_format_q;
	logic        blink_en_q;
	logic [15:0] toggle_period_q;
	logic        wr;
	cfg_t        cfg;
	logic        q_push;
	unit_t       q_wdata;
	logic        q_full;
	logic        q_pop;
	logic        q_valid;
	unit_t       q_rdata;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q  <= FMT_TEXT;
			blink_en_q      <= 1'b0;
			toggle_period_q <= TOGGLE_PERIOD_RESET;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_PIXEL_FORMAT:  pixel_format_q  <= pwdata[2:0];
				REG_BLINK_EN:      blink_en_q      <= pwdata[0];
				REG_TOGGLE_PERIOD: toggle_period_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register read-back
	always_comb begin
		unique case (paddr[3:2])
			REG_PIXEL_FORMAT:  prdata = {29'd0, pixel_format_q};
			REG_BLINK_EN:      prdata = {31'd0, blink_en_q};
			REG_TOGGLE_PERIOD: prdata = {16'd0, toggle_period_q};
			default:           prdata = 32'd0;
		endcase
	end

	always_comb begin
		cfg.pixel_format      = pixel_format_q;
		cfg.text_blink_enable = blink_en_q;
		cfg.toggle_period     = toggle_period_q;
		cfg.rate_wr           = wr && paddr[3:2] == REG_TOGGLE_PERIOD;
		cfg.rate_wdata        = pwdata[15:0];
	end

	tgpg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	tgpg_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rdata    (q_rdata)
	);

	tgpg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (q_rdata),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// ----- rtl/tgpg_fifo.sv -----
// Short queue of classified units between front and back ends.
// Depends on tgpg_pkg (unit_t).
module tgpg_fifo import tgpg_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  unit_t wdata,
	output logic  full,
	input  logic  pop,
	output logic  rd_valid,
	output unit_t rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	unit_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [PW-1:0] next_ptr(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rdata    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			case ({push, pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/tgpg_front.sv -----
// Front end: accepts items, runs the blink counter, classifies fetched units.
// Depends on tgpg_pkg (cfg_t, unit_t, attr_levels).
module tgpg_front import tgpg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        s_tuser,
	input  logic        q_full,
	output logic        q_push,
	output unit_t       q_wdata
);
	logic        blink_phase_q;
	logic [15:0] blink_count_q;
	logic        accept;
	logic [15:0] data_word;
	logic [15:0] glyph_row;
	logic [7:0]  attribute;
	logic [15:0] cursor_mask;
	logic [15:0] glyph_v;
	logic [7:0]  attr_eff;
	levels_t     lv;
	logic        fmt_ok;

	assign data_word   = s_tdata[15:0];
	assign glyph_row   = s_tdata[31:16];
	assign attribute   = s_tdata[39:32];
	assign cursor_mask = s_tdata[55:40];

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// blink phase and frame counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_phase_q <= 1'b1;
			blink_count_q <= TOGGLE_PERIOD_RESET;
		end else if (cfg.rate_wr) begin
			blink_phase_q <= 1'b1;
			blink_count_q <= cfg.rate_wdata;
		end else if (accept && s_tuser == OP_TICK && blink_count_q != 16'd0) begin
			if (blink_count_q == 16'd1) begin
				blink_phase_q <= !blink_phase_q;
				blink_count_q <= cfg.toggle_period;
			end else begin
				blink_count_q <= blink_count_q - 16'd1;
			end
		end
	end

	// text cell: cursor overlay and blink handling of the attribute
	always_comb begin
		glyph_v  = glyph_row | (blink_phase_q ? cursor_mask : 16'h0000);
		attr_eff = attribute;
		if (cfg.text_blink_enable && attribute[7]) begin
			if (blink_phase_q)
				attr_eff = {1'b0, attribute[6:0]};
			else
				attr_eff = {1'b0, attribute[6:4], 1'b0, attribute[6:4]};
		end
		lv = attr_levels(attr_eff);
	end

	// unit descriptor per format
	always_comb begin
		q_wdata = '{bits: data_word, two_bpp: 1'b0, last_idx: 4'd15,
			fg: GREY_WHITE, bg: GREY_BLACK};
		fmt_ok  = 1'b1;
		unique case (cfg.pixel_format)
			FMT_TEXT: begin
				q_wdata.bits = glyph_v;
				q_wdata.fg   = lv.fg;
				q_wdata.bg   = lv.bg;
			end
			FMT_WORD_2BPP: begin
				q_wdata.two_bpp  = 1'b1;
				q_wdata.last_idx = 4'd7;
			end
			FMT_WORD_1BPP: begin
				q_wdata.last_idx = 4'd15;
			end
			FMT_BYTE_1BPP: begin
				q_wdata.bits     = {data_word[7:0], 8'h00};
				q_wdata.last_idx = 4'd7;
			end
			FMT_BYTE_2BPP: begin
				q_wdata.bits     = {data_word[7:0], 8'h00};
				q_wdata.two_bpp  = 1'b1;
				q_wdata.last_idx = 4'd3;
			end
			default: fmt_ok = 1'b0;
		endcase
	end

	// unused formats drop the unit
	assign q_push = accept && s_tuser == OP_UNIT && fmt_ok;

endmodule

// ----- rtl/tgpg_back.sv -----
// Back end: expands one queued unit into grey pixels, one per clock while the output is not stalled.
// Depends on tgpg_pkg (unit_t) and the assertion macro header.
`include "text_graphics_pixel_generator_top_defines.svh"
module tgpg_back import tgpg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  unit_t      head,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);
	logic        busy_q;
	logic [15:0] bits_q;
	logic        two_q;
	logic [3:0]  remain_q;
	logic [7:0]  fg_q;
	logic [7:0]  bg_q;
	logic        m_tvalid_q;
	logic [7:0]  grey_q;
	logic        last_q;
	logic        adv;
	logic        load;
	logic [7:0]  pix;

	// advance one pixel when the output register is free
	assign adv  = busy_q && (!m_tvalid_q || m_tready);
	// next unit enters as the last pixel of this one leaves
	assign load = head_valid && (!busy_q || (adv && remain_q == 4'd0));
	assign pop  = load;

	assign pix = two_q ? {4{bits_q[15:14]}} : (bits_q[15] ? fg_q : bg_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load)
				busy_q <= 1'b1;
			else if (adv && remain_q == 4'd0)
				busy_q <= 1'b0;
			if (adv)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// shifter and output register
	always_ff @(posedge clk) begin
		if (load) begin
			bits_q   <= head.bits;
			two_q    <= head.two_bpp;
			remain_q <= head.last_idx;
			fg_q     <= head.fg;
			bg_q     <= head.bg;
		end else if (adv) begin
			bits_q   <= two_q ? {bits_q[13:0], 2'b00} : {bits_q[14:0], 1'b0};
			remain_q <= remain_q - 4'd1;
		end
		if (adv) begin
			grey_q <= pix;
			last_q <= (remain_q == 4'd0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = grey_q;
	assign m_tlast  = last_q;

	`TGPG_ASSERT(a_two_bpp_short, busy_q && two_q |-> remain_q <= 4'd7, "2bpp unit too long")
	`TGPG_ASSERT(a_count_down, adv && remain_q != 4'd0 && !load |=> busy_q && remain_q == $past(remain_q) - 4'd1, "pixel count slip")
	`TGPG_ASSERT(a_idle_after_last, adv && remain_q == 4'd0 && !head_valid |=> !busy_q, "unit ran past its last pixel")
	`TGPG_ASSERT_NR(a_reset_quiet, !arst_n |-> !busy_q && !m_tvalid_q, "activity during reset")

endmodule
